// ===== rtl/core/tflu_pkg.sv =====
// Shared types and constants for the FIFO-replacement TLB block.
package tflu_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int OP_W    = 2;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 32;

    // operation, page, frame = 18 bits, padded to 3 bytes
    localparam int IN_TDATA_W  = 24;
    // found, frame_out, slot_index, hit_count, fault_count = 77 bits, padded to 10 bytes
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic match;     // register the compare vectors
        logic commit;    // update the entries and load the result
    } ctrl_cmd_t;

endpackage

// ===== rtl/core/tflu_ctrl.sv =====
// Sequencer for the TLB: request capture, compare, resolve, result handshake.
module tflu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tflu_pkg::ctrl_cmd_t cmd
);
    import tflu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_MATCH   = 3'b010,
        ST_RESOLVE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.match   = (state_reg == ST_MATCH);
    assign cmd.commit  = (state_reg == ST_RESOLVE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                // hold until the result register is free
                if (cmd.commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_capture_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_MATCH))
        else $error("captured request did not enter compare");

    a_match_to_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |=> (state_reg == ST_RESOLVE))
        else $error("compare did not advance to resolve");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_stall_holds_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESOLVE) && m_tvalid && !m_tready) |=> (state_reg == ST_RESOLVE))
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/tflu_datapath.sv =====
// TLB entry store, parallel compare, lowest-index select, counters and result register.
module tflu_datapath #(
    parameter int ENTRIES = tflu_pkg::ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tflu_pkg::ctrl_cmd_t                cmd,
    input  logic [tflu_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic [tflu_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import tflu_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PAD_W = OUT_TDATA_W - (1 + FRAME_W + SLOT_W + 2 * CNT_W);

    // captured request
    op_t                op_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [FRAME_W-1:0] frame_reg;

    // entry store
    logic [PAGE_W-1:0]  entry_page_reg  [ENTRIES];
    logic [FRAME_W-1:0] entry_frame_reg [ENTRIES];
    logic [ENTRIES-1:0] entry_valid_reg;
    logic [ENTRIES-1:0] entry_written_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_inc;

    logic [ENTRIES-1:0] page_hit_reg;
    logic [ENTRIES-1:0] frame_hit_reg;

    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   faults_reg;

    logic               found_reg;
    logic [FRAME_W-1:0] frame_out_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               found_next;
    logic [FRAME_W-1:0] frame_out_next;
    logic [SLOT_W-1:0]  slot_next;

    logic [ENTRIES-1:0] sel_vec;
    logic [ENTRIES-1:0] sel_onehot;
    logic               sel_any;
    logic [IDX_W-1:0]   sel_idx;
    logic [FRAME_W-1:0] sel_frame;
    logic [SLOT_W-1:0]  sel_slot;
    logic [SLOT_W-1:0]  ins_slot;
    logic [SLOT_W+IDX_W-1:0] sel_slot_ext;
    logic [SLOT_W+IDX_W-1:0] ins_slot_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(s_tdata[OP_W-1:0]);
            page_reg  <= s_tdata[OP_W +: PAGE_W];
            frame_reg <= s_tdata[OP_W+PAGE_W +: FRAME_W];
        end
    end

    // compare every entry in place
    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                page_hit_reg[i]  <= entry_valid_reg[i] && (entry_page_reg[i] == page_reg);
                frame_hit_reg[i] <= entry_written_reg[i] && (entry_frame_reg[i] == frame_reg);
            end
        end
    end

    assign sel_vec    = (op_reg == OP_LOOKUP) ? page_hit_reg : frame_hit_reg;
    // isolate the lowest set bit
    assign sel_onehot = sel_vec & (~sel_vec + ENTRIES'(1));
    assign sel_any    = |sel_vec;

    always_comb
    begin
        sel_idx   = '0;
        sel_frame = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel_onehot[i])
            begin
                sel_idx   = sel_idx | IDX_W'(i);
                sel_frame = sel_frame | entry_frame_reg[i];
            end
        end
    end

    assign ptr_inc = (ptr_reg == IDX_W'(ENTRIES - 1)) ? '0 : ptr_reg + IDX_W'(1);

    // slot field carries the low bits of the entry number
    assign sel_slot_ext = {{SLOT_W{1'b0}}, sel_idx};
    assign ins_slot_ext = {{SLOT_W{1'b0}}, ptr_inc};
    assign sel_slot     = sel_slot_ext[SLOT_W-1:0];
    assign ins_slot     = ins_slot_ext[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == OP_INSERT))
        begin
            entry_page_reg[ptr_inc]  <= page_reg;
            entry_frame_reg[ptr_inc] <= frame_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg   <= '0;
            entry_written_reg <= '0;
            ptr_reg           <= IDX_W'(ENTRIES - 1);
            hits_reg          <= '0;
            faults_reg        <= '0;
        end
        else if (cmd.commit)
        begin
            unique case (op_reg)
                OP_LOOKUP:
                begin
                    if (sel_any)
                        hits_reg <= hits_reg + CNT_W'(1);
                    else
                        faults_reg <= faults_reg + CNT_W'(1);
                end
                OP_INSERT:
                begin
                    ptr_reg                    <= ptr_inc;
                    entry_valid_reg[ptr_inc]   <= 1'b1;
                    entry_written_reg[ptr_inc] <= 1'b1;
                end
                OP_INVAL:
                begin
                    if (sel_any)
                        entry_valid_reg[sel_idx] <= 1'b0;
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        found_next     = 1'b0;
        frame_out_next = '0;
        slot_next      = '0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (sel_any)
                begin
                    found_next     = 1'b1;
                    frame_out_next = sel_frame;
                    slot_next      = sel_slot;
                end
            end
            OP_INSERT:
            begin
                slot_next = ins_slot;
            end
            OP_INVAL:
            begin
                if (sel_any)
                begin
                    found_next = 1'b1;
                    slot_next  = sel_slot;
                end
            end
            OP_NONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            found_reg     <= found_next;
            frame_out_reg <= frame_out_next;
            slot_reg      <= slot_next;
        end
    end

    // counters only move on commit, so they stay with the waiting result
    assign m_tdata = {{PAD_W{1'b0}}, faults_reg, hits_reg, slot_reg, frame_out_reg, found_reg};

endmodule

// ===== rtl/core/tlb_fifo_lookup_invalidate_unit.sv =====
// Top level of the fully associative TLB with FIFO replacement.
//
// Requests arrive on the s_ group (tvalid/tready/tdata); each carries an
// operation (lookup by page, insert page and frame, invalidate by frame, or none).
// Every request produces exactly one result on the m_ group with the found
// flag, the frame of a lookup hit, the slot touched and the running hit and
// fault counters.
// A request is latched by the capture register, then compared against all
// entries in parallel into a registered match vector; the resolve step
// picks the lowest-index match and updates the store. One request is in
// flight at a time, so the block takes no new request until the last one
// has left the resolve step.
// A waiting result sits in an output register, so the next request is
// accepted and compared while the receiver stalls; it then holds in the
// resolve step until the output register is taken.
// Reset clears all valid and written flags, both counters and the result
// valid, and sets the replacement pointer so the first insert uses slot 0.
module tlb_fifo_lookup_invalidate_unit #(
    parameter int ENTRIES = tflu_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[1:0], page[9:2], frame[17:10], zero pad
    input  logic [tflu_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found[0], frame_out[8:1], slot_index[12:9], hit_count[44:13],
    // fault_count[76:45], zero pad
    output logic [tflu_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tflu_pkg::*;

    ctrl_cmd_t cmd;

    tflu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tflu_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ===== dv/tlb_fifo_lookup_invalidate_unit_tb.sv =====
// Self-checking testbench for the FIFO-replacement TLB: directed cases plus random traffic.
`timescale 1ns / 100ps

module tlb_fifo_lookup_invalidate_unit_tb;

    import tflu_pkg::*;

    localparam int ENTRIES       = ENTRIES_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_PER_PHASE = 458;

    typedef struct packed {
        logic [CNT_W-1:0]   fault_count;
        logic [CNT_W-1:0]   hit_count;
        logic [SLOT_W-1:0]  slot_index;
        logic [FRAME_W-1:0] frame_out;
        logic               found;
    } tlb_reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // operation[1:0], page[9:2], frame[17:10], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // found[0], frame_out[8:1], slot_index[12:9], hit_count[44:13],
    // fault_count[76:45], zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the translation table
    bit   [PAGE_W-1:0]  tlb_page    [ENTRIES];
    bit   [FRAME_W-1:0] tlb_frame   [ENTRIES];
    bit                 tlb_valid   [ENTRIES];
    bit                 tlb_written [ENTRIES];
    int                 fifo_ptr    = ENTRIES - 1;
    bit   [CNT_W-1:0]   hit_total   = '0;
    bit   [CNT_W-1:0]   fault_total = '0;

    tlb_reply_t replies_due[$];
    int         error_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         cycle_count    = 0;

    tlb_fifo_lookup_invalidate_unit #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Apply one request to the shadow table and return the reply it must produce.
    function automatic tlb_reply_t tlb_apply(op_t op, logic [PAGE_W-1:0] page,
                                             logic [FRAME_W-1:0] frame);
        tlb_reply_t reply;
        int         hit_slot;
        reply    = '0;
        hit_slot = -1;
        case (op)
            OP_LOOKUP:
            begin
                // scan downward so the lowest matching slot wins
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (tlb_valid[i] && tlb_page[i] == page)
                        hit_slot = i;
                end
                if (hit_slot >= 0)
                begin
                    reply.found      = 1'b1;
                    reply.frame_out  = tlb_frame[hit_slot];
                    reply.slot_index = SLOT_W'(hit_slot);
                    hit_total++;
                end
                else
                begin
                    fault_total++;
                end
            end
            OP_INSERT:
            begin
                fifo_ptr = (fifo_ptr == ENTRIES - 1) ? 0 : fifo_ptr + 1;
                tlb_page[fifo_ptr]    = page;
                tlb_frame[fifo_ptr]   = frame;
                tlb_valid[fifo_ptr]   = 1'b1;
                tlb_written[fifo_ptr] = 1'b1;
                reply.slot_index      = SLOT_W'(fifo_ptr);
            end
            OP_INVAL:
            begin
                // a written slot matches even after it was invalidated
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (tlb_written[i] && tlb_frame[i] == frame)
                        hit_slot = i;
                end
                if (hit_slot >= 0)
                begin
                    tlb_valid[hit_slot] = 1'b0;
                    reply.found         = 1'b1;
                    reply.slot_index    = SLOT_W'(hit_slot);
                end
            end
            default:
            begin
            end
        endcase
        reply.hit_count   = hit_total;
        reply.fault_count = fault_total;
        return reply;
    endfunction

    function automatic void flag_field(string field, logic [CNT_W-1:0] want,
                                       logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    function automatic void check_reply(tlb_reply_t got);
        tlb_reply_t want;
        if (replies_due.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected reply %h with no request outstanding", got);
            return;
        end
        want = replies_due.pop_front();
        flag_field("found",       CNT_W'(want.found),      CNT_W'(got.found));
        flag_field("frame_out",   CNT_W'(want.frame_out),  CNT_W'(got.frame_out));
        flag_field("slot_index",  CNT_W'(want.slot_index), CNT_W'(got.slot_index));
        flag_field("hit_count",   want.hit_count,          got.hit_count);
        flag_field("fault_count", want.fault_count,        got.fault_count);
    endfunction

    // Reply side: check at each accepting edge, then pick the next ready level.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                check_reply(tlb_reply_t'(m_tdata[$bits(tlb_reply_t)-1:0]));
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tlb_fifo_lookup_invalidate_unit_tb NOT OK");
        $finish;
    end

    // Send one request; return at the edge that accepted it.
    task automatic send_request(input op_t op, input logic [PAGE_W-1:0] page,
                                input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - OP_W - PAGE_W - FRAME_W){1'b0}}, frame, page, op};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        replies_due.push_back(tlb_apply(op, page, frame));
    endtask

    // Hold off new requests until every outstanding reply has come back.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_request(OP_LOOKUP, 8'h00, 8'h00);
        send_request(OP_INVAL,  8'h00, 8'h00);
    endtask

    task automatic test_unused_opcode();
        send_request(OP_NONE, 8'hFF, 8'hFF);
        send_request(OP_NONE, 8'h00, 8'h00);
    endtask

    task automatic test_hits_and_duplicates();
        send_request(OP_INSERT, 8'h00, 8'h00);
        send_request(OP_INSERT, 8'hFF, 8'hFF);
        send_request(OP_INSERT, 8'hFF, 8'h5A);
        send_request(OP_LOOKUP, 8'hFF, 8'hA5);
        send_request(OP_LOOKUP, 8'h00, 8'hFF);
        send_request(OP_LOOKUP, 8'h7E, 8'h00);
    endtask

    task automatic test_invalidate_rules();
        send_request(OP_INVAL,  8'hA5, 8'hFF);
        send_request(OP_LOOKUP, 8'hFF, 8'h00);
        // slot stays written, so the same frame matches again
        send_request(OP_INVAL,  8'h00, 8'hFF);
        send_request(OP_INVAL,  8'h00, 8'h5A);
        send_request(OP_LOOKUP, 8'hFF, 8'h00);
        send_request(OP_INVAL,  8'h00, 8'h00);
        send_request(OP_INVAL,  8'hFF, 8'h00);
        send_request(OP_NONE,   8'h5A, 8'hA5);
    endtask

    // Random mix of inserts, lookups, invalidates and no-ops; lookups and invalidates mostly aim at written entries.
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        op_t                op;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        int                 pick;
        int                 slot;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
        begin
            pick  = $urandom_range(99);
            slot  = $urandom_range(ENTRIES - 1);
            page  = PAGE_W'($urandom_range(255));
            frame = FRAME_W'($urandom_range(255));
            if (pick < 32)
            begin
                op = OP_INSERT;
                // narrow pools give duplicate pages and frames
                if ($urandom_range(3) != 0)
                    page = PAGE_W'($urandom_range(23));
                if ($urandom_range(3) == 0)
                    frame = FRAME_W'($urandom_range(15));
            end
            else if (pick < 72)
            begin
                op = OP_LOOKUP;
                if ($urandom_range(9) < 7 && tlb_written[slot])
                    page = tlb_page[slot];
            end
            else if (pick < 92)
            begin
                op = OP_INVAL;
                if ($urandom_range(9) < 7 && tlb_written[slot])
                    frame = tlb_frame[slot];
            end
            else
            begin
                op = OP_NONE;
            end
            send_request(op, page, frame);
        end
        wait_for_replies();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_unused_opcode();
        test_hits_and_duplicates();
        test_invalidate_rules();
        wait_for_replies();

        test_random_traffic(0,  0,  RANDOM_PER_PHASE);
        test_random_traffic(77, 0,  RANDOM_PER_PHASE);
        test_random_traffic(0,  77, RANDOM_PER_PHASE);
        test_random_traffic(20, 20, RANDOM_PER_PHASE);

        if (error_count == 0)
            $display("tlb_fifo_lookup_invalidate_unit_tb OK");
        else
            $display("tlb_fifo_lookup_invalidate_unit_tb NOT OK");
        $finish;
    end

endmodule
